// File: rtl/skyline_block_allocator_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the skyline block allocator
// Shared property forms used by the RTL checks of this block.
// ----------------------------------------------------------------------------
`ifndef SKYLINE_BLOCK_ALLOCATOR_TOP_ASSERT_SVH
`define SKYLINE_BLOCK_ALLOCATOR_TOP_ASSERT_SVH

// The expression must never be true outside reset.
`define SBA_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error(msg);

// The consequence must hold in the same cycle as the condition.
`define SBA_ASSERT_IMPLY(lbl, cond, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (cons)) \
        else $error(msg);

// The consequence must hold in the cycle after the condition.
`define SBA_ASSERT_NEXT(lbl, cond, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/sba_pkg.sv
// ----------------------------------------------------------------------------
// Skyline block allocator package
// Default sizes, codes and the control bundle of the column scan.
// ----------------------------------------------------------------------------
package sba_pkg;

    localparam int COLUMNS_DEF     = 128;
    localparam int PAGE_HEIGHT_DEF = 128;

    localparam logic [3:0] LAST_PAGE_RST = 4'd14;

    localparam logic KIND_CLEAR    = 1'b1;
    localparam logic REG_LAST_PAGE = 1'b0;

    typedef struct packed {
        logic clr;
        logic p1_vld;
        logic p2_rd;
        logic p2_vld;
    } t_scan_ctl;

endpackage

// File: rtl/skyline_block_allocator_top.sv
// ----------------------------------------------------------------------------
// Skyline block allocator
// Places blocks on pages by keeping one filled height per column in a
// synchronous memory, with page flush, refusal at the last page and clear.
//
//   Channel   Handshake                      Payload
//   command   start, busy                    i_kind, i_block_width, i_block_height
//   result    o_valid (one-cycle strobe)     o_granted, o_pos_x, o_pos_y, o_page,
//                                            o_flush_height
//   config    psel, penable, pwrite, pready  paddr, pwdata, prdata (last_page)
//
// An allocation reads all columns forward, then all but the last column
// backward, passes the drain and decision states and writes back w columns,
// or all COLUMNS columns when the page is flushed; a refused item writes none.
// A clear item zeroes all columns; an impossible size is refused without a scan.
// After reset the column memory is zeroed with busy high.
// The result strobe lasts one cycle and cannot be held off.
// ----------------------------------------------------------------------------
`include "skyline_block_allocator_top_assert.svh"

module skyline_block_allocator_top #(
    parameter int COLUMNS     = sba_pkg::COLUMNS_DEF,
    parameter int PAGE_HEIGHT = sba_pkg::PAGE_HEIGHT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_kind,
    input  logic [7:0]  i_block_width,
    input  logic [7:0]  i_block_height,
    output logic        o_valid,
    output logic        o_granted,
    output logic [6:0]  o_pos_x,
    output logic [6:0]  o_pos_y,
    output logic [3:0]  o_page,
    output logic [7:0]  o_flush_height,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sba_pkg::*;

    localparam int AW  = $clog2(COLUMNS);
    localparam int CW  = $clog2(COLUMNS + 1);
    localparam int HW  = $clog2(PAGE_HEIGHT + 1);
    localparam int XW0 = (CW > HW) ? CW : HW;
    localparam int XW  = ((XW0 > 8) ? XW0 : 8) + 1;

    localparam logic [2:0] ST_WR    = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_P1    = 3'd2;
    localparam logic [2:0] ST_P2    = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;
    localparam logic [2:0] ST_DEC   = 3'd5;
    localparam logic [2:0] ST_EMIT  = 3'd6;
    localparam logic [2:0] ST_SPARE = 3'd7;

    logic [2:0]    r_state,     n_state;
    logic [CW-1:0] r_addr,      n_addr;
    logic [CW-1:0] r_wend,      n_wend;
    logic [CW-1:0] r_wlim,      n_wlim;
    logic [HW-1:0] r_wval,      n_wval;
    logic          r_emit,      n_emit;
    logic [7:0]    r_w,         n_w;
    logic [7:0]    r_h,         n_h;
    logic          r_dv1,       n_dv1;
    logic          r_dv2,       n_dv2;
    logic [AW-1:0] r_daddr,     n_daddr;
    logic [3:0]    r_page,      n_page;
    logic [3:0]    r_last_page, n_last_page;
    logic          r_valid,     n_valid;
    logic          r_granted,   n_granted;
    logic [6:0]    r_x,         n_x;
    logic [6:0]    r_y,         n_y;
    logic [3:0]    r_opage,     n_opage;
    logic [7:0]    r_flush,     n_flush;

    logic [HW-1:0] r_col_mem [COLUMNS];
    logic [HW-1:0] r_col_rd;

    logic          accept;
    logic          size_ok;
    logic          fit;
    logic [CW-1:0] place_end;
    logic          col_we;
    logic          col_re;
    logic [HW-1:0] col_wdata;
    logic          cfg_wr;
    t_scan_ctl     scan_ctl;
    logic [HW-1:0] s_best;
    logic [AW-1:0] s_bx;
    logic [HW-1:0] s_gmax;

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_LAST_PAGE);
    assign prdata = (paddr[2] == REG_LAST_PAGE) ? {28'd0, r_last_page} : 32'd0;

    assign col_we    = (r_state == ST_WR);
    assign col_re    = (r_state == ST_P1) || (r_state == ST_P2);
    assign col_wdata = (r_addr < r_wlim) ? r_wval : '0;

    assign scan_ctl.clr    = accept;
    assign scan_ctl.p1_vld = r_dv1;
    assign scan_ctl.p2_rd  = (r_state == ST_P2);
    assign scan_ctl.p2_vld = r_dv2;

    always_ff @(posedge i_clk) begin
        if (col_we) begin
            r_col_mem[r_addr[AW-1:0]] <= col_wdata;
        end
        if (col_re) begin
            r_col_rd <= r_col_mem[r_addr[AW-1:0]];
        end
    end

    sba_scan #(
        .COLUMNS     (COLUMNS),
        .PAGE_HEIGHT (PAGE_HEIGHT)
    ) u_scan (
        .i_clk      (i_clk),
        .i_ctl      (scan_ctl),
        .i_rd_addr  (r_addr[AW-1:0]),
        .i_dat_addr (r_daddr),
        .i_col      (r_col_rd),
        .i_width    (r_w),
        .o_best     (s_best),
        .o_bx       (s_bx),
        .o_gmax     (s_gmax)
    );

    always_comb begin
        size_ok = (i_block_width != 8'd0)
               && (XW'(i_block_width) <= XW'(COLUMNS - 1))
               && (i_block_height != 8'd0)
               && (XW'(i_block_height) <= XW'(PAGE_HEIGHT));
        fit       = (XW'(s_best) + XW'(r_h)) <= XW'(PAGE_HEIGHT);
        place_end = CW'(XW'(s_bx) + XW'(r_w));

        n_state     = r_state;
        n_addr      = r_addr;
        n_wend      = r_wend;
        n_wlim      = r_wlim;
        n_wval      = r_wval;
        n_emit      = r_emit;
        n_w         = r_w;
        n_h         = r_h;
        n_dv1       = (r_state == ST_P1);
        n_dv2       = (r_state == ST_P2);
        n_daddr     = r_addr[AW-1:0];
        n_page      = r_page;
        n_last_page = cfg_wr ? pwdata[3:0] : r_last_page;
        n_valid     = 1'b0;
        n_granted   = r_granted;
        n_x         = r_x;
        n_y         = r_y;
        n_opage     = r_opage;
        n_flush     = r_flush;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_w       = i_block_width;
                    n_h       = i_block_height;
                    n_granted = 1'b0;
                    n_x       = 7'd0;
                    n_y       = 7'd0;
                    n_flush   = 8'd0;
                    n_opage   = r_page;
                    n_addr    = '0;
                    if (i_kind == KIND_CLEAR) begin
                        n_page  = 4'd0;
                        n_opage = 4'd0;
                        n_wend  = CW'(COLUMNS);
                        n_wlim  = '0;
                        n_wval  = '0;
                        n_emit  = 1'b1;
                        n_state = ST_WR;
                    end else if (!size_ok) begin
                        n_state = ST_EMIT;
                    end else begin
                        n_state = ST_P1;
                    end
                end
            end
            ST_P1: begin
                if (r_addr == CW'(COLUMNS - 1)) begin
                    n_addr  = CW'(COLUMNS - 2);
                    n_state = ST_P2;
                end else begin
                    n_addr = r_addr + CW'(1);
                end
            end
            ST_P2: begin
                if (r_addr == '0) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_addr = r_addr - CW'(1);
                end
            end
            ST_DRAIN: begin
                n_state = ST_DEC;
            end
            ST_DEC: begin
                if (fit) begin
                    n_granted = 1'b1;
                    n_x       = 7'(s_bx);
                    n_y       = 7'(s_best);
                    n_addr    = CW'(s_bx);
                    n_wend    = place_end;
                    n_wlim    = place_end;
                    n_wval    = HW'(XW'(s_best) + XW'(r_h));
                    n_emit    = 1'b1;
                    n_state   = ST_WR;
                end else if (r_page == r_last_page) begin
                    n_state = ST_EMIT;
                end else begin
                    n_page    = r_page + 4'd1;
                    n_opage   = r_page + 4'd1;
                    n_granted = 1'b1;
                    n_flush   = 8'(s_gmax);
                    n_addr    = '0;
                    n_wend    = CW'(COLUMNS);
                    n_wlim    = CW'(r_w);
                    n_wval    = HW'(r_h);
                    n_emit    = 1'b1;
                    n_state   = ST_WR;
                end
            end
            ST_WR: begin
                n_addr = r_addr + CW'(1);
                if ((r_addr + CW'(1)) == r_wend) begin
                    n_valid = r_emit;
                    n_state = ST_IDLE;
                end
            end
            ST_EMIT: begin
                n_valid = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_WR;
            r_addr      <= '0;
            r_wend      <= CW'(COLUMNS);
            r_wlim      <= '0;
            r_wval      <= '0;
            r_emit      <= 1'b0;
            r_dv1       <= 1'b0;
            r_dv2       <= 1'b0;
            r_page      <= 4'd0;
            r_last_page <= LAST_PAGE_RST;
            r_valid     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_wend      <= n_wend;
            r_wlim      <= n_wlim;
            r_wval      <= n_wval;
            r_emit      <= n_emit;
            r_dv1       <= n_dv1;
            r_dv2       <= n_dv2;
            r_page      <= n_page;
            r_last_page <= n_last_page;
            r_valid     <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w       <= n_w;
        r_h       <= n_h;
        r_daddr   <= n_daddr;
        r_granted <= n_granted;
        r_x       <= n_x;
        r_y       <= n_y;
        r_opage   <= n_opage;
        r_flush   <= n_flush;
    end

    assign o_valid        = r_valid;
    assign o_granted      = r_granted;
    assign o_pos_x        = r_x;
    assign o_pos_y        = r_y;
    assign o_page         = r_opage;
    assign o_flush_height = r_flush;

    `SBA_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy, "Accepted item did not raise busy.")
    `SBA_ASSERT_IMPLY(a_result_after_work, o_valid, $past(busy), "Result without prior work.")
    `SBA_ASSERT_IMPLY(a_refusal_at_origin, o_valid && !o_granted, (o_pos_x == 7'd0) && (o_pos_y == 7'd0), "Refused item reports a position.")
    `SBA_ASSERT_IMPLY(a_flush_grants, o_valid && (o_flush_height != 8'd0), o_granted, "Flushed page did not grant the item.")
    `SBA_ASSERT_NEVER(a_mem_rw_exclusive, col_we && col_re, "Column memory read and written in one cycle.")

endmodule

// File: rtl/sba_scan.sv
// ----------------------------------------------------------------------------
// Skyline block allocator column scan
// Finds the leftmost lowest window maximum with a two-pass block method: the
// forward pass stores in-block prefix maxima in a scratch memory, the
// backward pass forms suffix maxima and combines them with stored prefixes.
// ----------------------------------------------------------------------------
module sba_scan #(
    parameter int COLUMNS     = sba_pkg::COLUMNS_DEF,
    parameter int PAGE_HEIGHT = sba_pkg::PAGE_HEIGHT_DEF
) (
    input  logic                               i_clk,
    input  sba_pkg::t_scan_ctl                 i_ctl,
    input  logic [$clog2(COLUMNS)-1:0]         i_rd_addr,
    input  logic [$clog2(COLUMNS)-1:0]         i_dat_addr,
    input  logic [$clog2(PAGE_HEIGHT+1)-1:0]   i_col,
    input  logic [7:0]                         i_width,
    output logic [$clog2(PAGE_HEIGHT+1)-1:0]   o_best,
    output logic [$clog2(COLUMNS)-1:0]         o_bx,
    output logic [$clog2(PAGE_HEIGHT+1)-1:0]   o_gmax
);
    import sba_pkg::*;

    localparam int AW  = $clog2(COLUMNS);
    localparam int HW  = $clog2(PAGE_HEIGHT + 1);
    localparam int N   = COLUMNS - 1;
    localparam int SW0 = (AW > 8) ? AW : 8;
    localparam int SW  = SW0 + 2;

    logic [HW-1:0] r_g_mem [N];
    logic [HW-1:0] r_g_rd;
    logic [HW-1:0] r_gmax;
    logic [HW-1:0] r_run;
    logic [7:0]    r_off;
    logic [7:0]    r_endoff;
    logic [HW-1:0] r_hs;
    logic [HW-1:0] r_best;
    logic [AW-1:0] r_bx;

    logic [7:0]    w_m1;
    logic [7:0]    off1;
    logic [HW-1:0] g;
    logic          g_we;
    logic [SW-1:0] g_rsum;
    logic [AW-1:0] g_raddr;
    logic          first;
    logic [7:0]    off2;
    logic [HW-1:0] hs;
    logic          win_ok;
    logic [HW-1:0] top;
    logic          take;

    always_comb begin
        w_m1 = i_width - 8'd1;
        if (i_dat_addr == '0) begin
            off1 = 8'd0;
        end else if (r_off == w_m1) begin
            off1 = 8'd0;
        end else begin
            off1 = r_off + 8'd1;
        end
        g    = ((off1 == 8'd0) || (i_col > r_run)) ? i_col : r_run;
        g_we = i_ctl.p1_vld && (SW'(i_dat_addr) < SW'(N));

        g_rsum  = SW'(i_rd_addr) + SW'(i_width) - SW'(1);
        g_raddr = (g_rsum < SW'(N)) ? AW'(g_rsum) : '0;

        first = (i_dat_addr == AW'(N - 1));
        if (first) begin
            off2 = r_endoff;
        end else if (r_off == 8'd0) begin
            off2 = w_m1;
        end else begin
            off2 = r_off - 8'd1;
        end
        hs     = (first || (off2 == w_m1) || (i_col > r_hs)) ? i_col : r_hs;
        win_ok = (SW'(i_dat_addr) + SW'(i_width)) <= SW'(N);
        top    = (hs > r_g_rd) ? hs : r_g_rd;
        take   = i_ctl.p2_vld && win_ok && (top <= r_best) && (top != HW'(PAGE_HEIGHT));
    end

    always_ff @(posedge i_clk) begin
        if (g_we) begin
            r_g_mem[i_dat_addr] <= g;
        end
        if (i_ctl.p2_rd) begin
            r_g_rd <= r_g_mem[g_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_gmax <= '0;
            r_best <= HW'(PAGE_HEIGHT);
            r_bx   <= '0;
        end else begin
            if (i_ctl.p1_vld) begin
                r_gmax <= (i_col > r_gmax) ? i_col : r_gmax;
                r_run  <= g;
                r_off  <= off1;
                if (first) begin
                    r_endoff <= off1;
                end
            end
            if (i_ctl.p2_vld) begin
                r_off <= off2;
                r_hs  <= hs;
                if (take) begin
                    r_best <= top;
                    r_bx   <= i_dat_addr;
                end
            end
        end
    end

    assign o_best = r_best;
    assign o_bx   = r_bx;
    assign o_gmax = r_gmax;

endmodule

// File: dv/sba_placement_checker.sv
// ----------------------------------------------------------------------------
// Placement checker for the skyline block allocator
// Watches the command, result and register channels, keeps its own skyline
// of column heights, page and last page, and compares every result strobe
// with the oldest predicted placement.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sba_placement_checker #(
    parameter int COLUMNS     = sba_pkg::COLUMNS_DEF,
    parameter int PAGE_HEIGHT = sba_pkg::PAGE_HEIGHT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic        i_kind,
    input  logic [7:0]  i_block_width,
    input  logic [7:0]  i_block_height,
    input  logic        i_valid,
    input  logic        i_granted,
    input  logic [6:0]  i_pos_x,
    input  logic [6:0]  i_pos_y,
    input  logic [3:0]  i_page,
    input  logic [7:0]  i_flush_height,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    output int          o_fail_count,
    output int          o_pending
);

    localparam logic [2:0] LAST_PAGE_ADDR = 3'(4 * sba_pkg::REG_LAST_PAGE);

    typedef struct packed {
        logic       granted;
        logic [6:0] pos_x;
        logic [6:0] pos_y;
        logic [3:0] page;
        logic [7:0] flush_height;
    } t_placement;

    logic [7:0] column_fill [COLUMNS];
    logic [3:0] cur_page;
    logic [3:0] last_page;
    t_placement expected_placements [$];
    int         mismatches;

    initial begin
        mismatches   = 0;
        cur_page     = '0;
        last_page    = sba_pkg::LAST_PAGE_RST;
        foreach (column_fill[i]) column_fill[i] = '0;
    end

    function automatic void empty_columns();
        foreach (column_fill[i]) column_fill[i] = '0;
    endfunction

    // Leftmost start column with the lowest window maximum; the last column
    // is never a start column.
    function automatic logic find_lowest_spot(input int w, output int x, output int y);
        int   best;
        int   top;
        logic found;
        best  = PAGE_HEIGHT;
        found = 1'b0;
        x     = 0;
        y     = 0;
        for (int i = 0; i + w + 1 <= COLUMNS; i++) begin
            top = 0;
            for (int j = 0; j < w; j++) begin
                if (column_fill[i + j] > top) top = column_fill[i + j];
            end
            if (top < best) begin
                x     = i;
                y     = top;
                best  = top;
                found = 1'b1;
            end
        end
        return found;
    endfunction

    function automatic t_placement place_block(input logic k, input int w, input int h);
        t_placement r;
        int         x;
        int         y;
        int         top;
        logic       fits;
        r = '0;
        x = 0;
        y = 0;
        if (k == sba_pkg::KIND_CLEAR) begin
            empty_columns();
            cur_page = '0;
        end else if (w != 0 && w + 1 <= COLUMNS && h != 0 && h <= PAGE_HEIGHT) begin
            fits = find_lowest_spot(w, x, y);
            fits = fits && (y + h <= PAGE_HEIGHT);
            if (!fits && cur_page != last_page) begin
                top = 0;
                foreach (column_fill[i]) begin
                    if (column_fill[i] > top) top = column_fill[i];
                end
                r.flush_height = 8'(top);
                empty_columns();
                cur_page = cur_page + 4'd1;
                fits = find_lowest_spot(w, x, y);
                fits = fits && (y + h <= PAGE_HEIGHT);
            end
            if (fits) begin
                for (int i = 0; i < w; i++) column_fill[x + i] = 8'(y + h);
                r.granted = 1'b1;
                r.pos_x   = 7'(x);
                r.pos_y   = 7'(y);
            end
        end
        r.page = cur_page;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_placement want;
        t_placement got;
        if (!i_rst_n) begin
            empty_columns();
            cur_page  = '0;
            last_page = sba_pkg::LAST_PAGE_RST;
            expected_placements.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == LAST_PAGE_ADDR) begin
                last_page = i_pwdata[3:0];
            end
            if (i_valid) begin
                got = '{i_granted, i_pos_x, i_pos_y, i_page, i_flush_height};
                if (expected_placements.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: result with no item waiting: granted=%0d x=%0d y=%0d",
                                 $realtime, got.granted, got.pos_x, got.pos_y);
                        $display("%0t:   page=%0d flush=%0d",
                                 $realtime, got.page, got.flush_height);
                    end
                end else begin
                    want = expected_placements.pop_front();
                    if (want.granted != got.granted || want.pos_x != got.pos_x ||
                        want.pos_y != got.pos_y || want.page != got.page ||
                        want.flush_height != got.flush_height) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: mismatch: expected granted=%0d x=%0d y=%0d",
                                     $realtime, want.granted, want.pos_x, want.pos_y);
                            $display("%0t:   expected page=%0d flush=%0d",
                                     $realtime, want.page, want.flush_height);
                            $display("%0t:   actual   granted=%0d x=%0d y=%0d",
                                     $realtime, got.granted, got.pos_x, got.pos_y);
                            $display("%0t:   actual   page=%0d flush=%0d",
                                     $realtime, got.page, got.flush_height);
                        end
                    end
                end
            end
            if (i_start && !i_busy) begin
                expected_placements.push_back(
                    place_block(i_kind, int'(i_block_width), int'(i_block_height)));
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_placements.size();
    end

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// Testbench top for the skyline block allocator
// Drives allocate and clear items and last page writes through phases of
// directed and random stimulus with random sender gaps; the placement
// checker predicts and compares, and this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    localparam logic [2:0] LAST_PAGE_ADDR = 3'(4 * sba_pkg::REG_LAST_PAGE);
    localparam int         QUIET_LIMIT    = 4000;
    localparam int         DRAIN_CYCLES   = 400;
    localparam logic       KIND_ALLOC     = ~sba_pkg::KIND_CLEAR;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_kind;
    logic [7:0]  i_block_width;
    logic [7:0]  i_block_height;
    logic        o_valid;
    logic        o_granted;
    logic [6:0]  o_pos_x;
    logic [6:0]  o_pos_y;
    logic [3:0]  o_page;
    logic [7:0]  o_flush_height;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    int          quiet_cycles;

    skyline_block_allocator_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_kind         (i_kind),
        .i_block_width  (i_block_width),
        .i_block_height (i_block_height),
        .o_valid        (o_valid),
        .o_granted      (o_granted),
        .o_pos_x        (o_pos_x),
        .o_pos_y        (o_pos_y),
        .o_page         (o_page),
        .o_flush_height (o_flush_height),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    sba_placement_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_kind         (i_kind),
        .i_block_width  (i_block_width),
        .i_block_height (i_block_height),
        .i_valid        (o_valid),
        .i_granted      (o_granted),
        .i_pos_x        (o_pos_x),
        .i_pos_y        (o_pos_y),
        .i_page         (o_page),
        .i_flush_height (o_flush_height),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .i_pready       (pready),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid || (psel && penable && pwrite)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic issue(input logic k, input logic [7:0] w, input logic [7:0] h,
                         input bit may_idle);
        if (may_idle && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_kind         <= k;
        i_block_width  <= w;
        i_block_height <= h;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0 || busy);
    endtask

    task automatic write_last_page(input logic [3:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LAST_PAGE_ADDR;
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic random_item(input bit may_idle);
        logic       k;
        logic [7:0] w;
        logic [7:0] h;
        int         roll;
        roll = $urandom_range(0, 99);
        k    = KIND_ALLOC;
        w    = 8'($urandom_range(1, 24));
        h    = 8'($urandom_range(1, 40));
        if (roll < 3) begin
            k = sba_pkg::KIND_CLEAR;
            w = 8'($urandom);
            h = 8'($urandom);
        end else if (roll < 8) begin
            if ($urandom_range(0, 1) == 1) begin
                w = ($urandom_range(0, 1) == 1) ? 8'd0 : 8'($urandom_range(128, 255));
            end else begin
                h = ($urandom_range(0, 1) == 1) ? 8'd0 : 8'($urandom_range(129, 255));
            end
        end else if (roll < 20) begin
            w = 8'($urandom_range(25, 127));
            h = 8'($urandom_range(1, 128));
        end else if (roll < 32) begin
            h = 8'($urandom_range(41, 128));
        end
        issue(k, w, h, may_idle);
    endtask

    initial begin
        logic [3:0] page_limits [5];
        page_limits     = '{4'd7, 4'd1, 4'd15, 4'd0, 4'd14};
        i_rst_n        <= 1'b0;
        start          <= 1'b0;
        i_kind         <= KIND_ALLOC;
        i_block_width  <= 8'd1;
        i_block_height <= 8'd1;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait_drained();

        write_last_page(4'd15);
        issue(KIND_ALLOC, 8'd1, 8'd1, 1'b1);
        issue(KIND_ALLOC, 8'd127, 8'd128, 1'b1);
        issue(KIND_ALLOC, 8'd1, 8'd1, 1'b1);
        issue(KIND_ALLOC, 8'd0, 8'd5, 1'b1);
        issue(KIND_ALLOC, 8'd128, 8'd5, 1'b1);
        issue(KIND_ALLOC, 8'd255, 8'd255, 1'b1);
        issue(KIND_ALLOC, 8'd10, 8'd0, 1'b1);
        issue(KIND_ALLOC, 8'd10, 8'd129, 1'b1);
        issue(sba_pkg::KIND_CLEAR, 8'd255, 8'd255, 1'b1);
        issue(KIND_ALLOC, 8'd64, 8'd64, 1'b1);
        issue(KIND_ALLOC, 8'd63, 8'd64, 1'b1);
        issue(KIND_ALLOC, 8'd64, 8'd64, 1'b1);
        issue(KIND_ALLOC, 8'd64, 8'd1, 1'b1);
        issue(KIND_ALLOC, 8'd2, 8'd127, 1'b1);
        wait_drained();

        // With the last page at zero, a full page refuses the next block.
        write_last_page(4'd0);
        issue(sba_pkg::KIND_CLEAR, 8'd0, 8'd0, 1'b1);
        issue(KIND_ALLOC, 8'd127, 8'd128, 1'b1);
        issue(KIND_ALLOC, 8'd1, 8'd1, 1'b1);
        issue(KIND_ALLOC, 8'd127, 8'd128, 1'b1);
        wait_drained();

        // Climb to page 15, then lower the last page so the page count wraps.
        write_last_page(4'd15);
        issue(sba_pkg::KIND_CLEAR, 8'($urandom), 8'($urandom), 1'b1);
        repeat (18) begin
            issue(KIND_ALLOC, 8'($urandom_range(100, 127)), 8'($urandom_range(100, 128)), 1'b1);
        end
        wait_drained();
        write_last_page(4'd3);
        repeat (8) begin
            issue(KIND_ALLOC, 8'($urandom_range(100, 127)), 8'($urandom_range(100, 128)), 1'b1);
        end

        foreach (page_limits[p]) begin
            wait_drained();
            write_last_page(page_limits[p]);
            for (int n = 0; n < 90; n++) begin
                random_item(!(p == 4 && n >= 30));
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
